[hdl/mste_pkg.sv]
// Shared types, codes and sizing constants for the multi-slot timer engine.
// Used by the controller, the datapath, the top level and the port checker.
package mste_pkg;

  localparam int SLOTS       = 16;
  localparam int FIELD_SLOTS = 16;
  localparam int LIVE_SLOTS  = (SLOTS < FIELD_SLOTS) ? SLOTS : FIELD_SLOTS;
  localparam int SLOT_W      = $clog2(LIVE_SLOTS);
  localparam int CNT_W       = $clog2(LIVE_SLOTS + 1);
  localparam int SLOT_FW     = 4;
  localparam int VAL_W       = 32;

  // Command kinds.
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_CREATE   = 3'd1;
  localparam logic [2:0] KIND_DESTROY  = 3'd2;
  localparam logic [2:0] KIND_PAUSE    = 3'd3;
  localparam logic [2:0] KIND_CONTINUE = 3'd4;
  localparam logic [2:0] KIND_RESET    = 3'd5;
  localparam logic [2:0] KIND_QUERY    = 3'd6;

  // Result events.
  localparam logic [2:0] EV_DONE     = 3'd0;
  localparam logic [2:0] EV_EXPIRED  = 3'd1;
  localparam logic [2:0] EV_FAILED   = 3'd2;
  localparam logic [2:0] EV_RUNNING  = 3'd3;
  localparam logic [2:0] EV_FINISHED = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [SLOT_FW-1:0] slot;
    logic [VAL_W-1:0]   period;
    logic               periodic;
    logic [7:0]         elapsed;
  } mste_in_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [SLOT_FW-1:0] which_slot;
    logic               last;
  } mste_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic              load;
    logic              rd_scan;
    logic [SLOT_W-1:0] scan_idx;
    logic              tick_proc;
    logic              tick_flush;
    logic              op_exec;
  } mste_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       elap_zero;
  } mste_sts_t;

endpackage

[hdl/mste_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mste_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/mste_ctrl.sv]
// Sequencing state machine of the timer engine: decode, slot scan, flush, execute.
// Depends on mste_pkg.
module mste_ctrl
  import mste_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mste_sts_t sts,
  output mste_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEC   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    cmd.rd_scan    = 1'b1;
    cmd.scan_idx   = cnt_r[SLOT_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        cnt_nxt = '0;
        if (sts.kind == KIND_TICK) begin
          state_nxt = sts.elap_zero ? ST_FLUSH : ST_SCAN;
        end else begin
          // Reset and query need the addressed slot's stored values next cycle.
          cmd.rd_scan = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end
      ST_SCAN: begin
        cmd.tick_proc = (cnt_r != '0);
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(LIVE_SLOTS)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.tick_flush = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_EXEC: begin
        cmd.op_exec = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/mste_dp.sv]
// Datapath of the timer engine: slot marks, reload and counter RAMs, tick
// arithmetic, command execution and the registered result word.
// Depends on mste_pkg and mste_ram.
module mste_dp
  import mste_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mste_in_t  in_word,
  input  mste_cmd_t cmd,
  output mste_sts_t sts,
  output mste_out_t out_word,
  output logic      out_strobe
);

  mste_in_t              in_r;
  logic [LIVE_SLOTS-1:0] used_r, used_nxt;
  logic [LIVE_SLOTS-1:0] hold_r, hold_nxt;
  logic [LIVE_SLOTS-1:0] cyc_r, cyc_nxt;
  logic [SLOT_W-1:0]     proc_idx_r;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  mste_out_t             out_word_r, out_word_nxt;

  logic [SLOT_W-1:0] slot_idx, rd_addr, free_idx;
  logic              free_found, live;
  logic [VAL_W-1:0]  cnt_q, rld_q, elap_ext, after_val;
  logic              active, expire;
  logic              cnt_we, rld_we;
  logic [SLOT_W-1:0] cnt_wa;
  logic [VAL_W-1:0]  cnt_wd;

  assign slot_idx = in_r.slot[SLOT_W-1:0];
  assign live     = (int'(in_r.slot) < LIVE_SLOTS) && used_r[slot_idx];
  assign rd_addr  = cmd.rd_scan ? cmd.scan_idx : slot_idx;

  assign sts.kind      = in_r.kind;
  assign sts.elap_zero = (in_r.elapsed == 8'd0);

  // Lowest free slot for create.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = LIVE_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // One slot of a tick: saturating subtract, expiry test, cyclic reload.
  assign elap_ext  = {{(VAL_W - 8){1'b0}}, in_r.elapsed};
  assign after_val = (elap_ext >= cnt_q) ? '0 : cnt_q - elap_ext;
  assign active    = used_r[proc_idx_r] && !hold_r[proc_idx_r];
  assign expire    = active && (after_val == '0) && (cyc_r[proc_idx_r] || (cnt_q != '0));

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = proc_idx_r;
    cnt_wd = after_val;
    rld_we = 1'b0;
    if (cmd.tick_proc && active) begin
      cnt_we = 1'b1;
      if (expire && cyc_r[proc_idx_r]) begin
        cnt_wd = rld_q;
      end
    end else if (cmd.op_exec && (in_r.kind == KIND_CREATE) && free_found) begin
      cnt_we = 1'b1;
      rld_we = 1'b1;
      cnt_wa = free_idx;
      cnt_wd = in_r.period;
    end else if (cmd.op_exec && (in_r.kind == KIND_RESET) && live) begin
      cnt_we = 1'b1;
      cnt_wa = slot_idx;
      cnt_wd = rld_q;
    end
  end

  mste_ram #(.WIDTH(VAL_W), .DEPTH(LIVE_SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_wa),
    .wdata (cnt_wd),
    .raddr (rd_addr),
    .rdata (cnt_q)
  );

  mste_ram #(.WIDTH(VAL_W), .DEPTH(LIVE_SLOTS)) u_rld_ram (
    .clk   (clk),
    .we    (rld_we),
    .waddr (free_idx),
    .wdata (in_r.period),
    .raddr (rd_addr),
    .rdata (rld_q)
  );

  always_comb begin
    used_nxt       = used_r;
    hold_nxt       = hold_r;
    cyc_nxt        = cyc_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = '0;

    if (cmd.load) begin
      pend_vld_nxt = 1'b0;
    end

    // An expiry is held back one step so the final one can carry last.
    if (cmd.tick_proc && expire) begin
      if (pend_vld_r) begin
        out_strobe_nxt          = 1'b1;
        out_word_nxt.event_res  = EV_EXPIRED;
        out_word_nxt.which_slot = SLOT_FW'(pend_idx_r);
      end
      pend_vld_nxt = 1'b1;
      pend_idx_nxt = proc_idx_r;
    end

    if (cmd.tick_flush) begin
      out_strobe_nxt    = 1'b1;
      out_word_nxt.last = 1'b1;
      if (pend_vld_r) begin
        out_word_nxt.event_res  = EV_EXPIRED;
        out_word_nxt.which_slot = SLOT_FW'(pend_idx_r);
      end else begin
        out_word_nxt.event_res = EV_DONE;
      end
      pend_vld_nxt = 1'b0;
    end

    if (cmd.op_exec) begin
      out_strobe_nxt          = 1'b1;
      out_word_nxt.last       = 1'b1;
      out_word_nxt.event_res  = EV_DONE;
      out_word_nxt.which_slot = in_r.slot;
      case (in_r.kind) inside
        KIND_CREATE: begin
          if (free_found) begin
            used_nxt[free_idx]      = 1'b1;
            hold_nxt[free_idx]      = 1'b0;
            cyc_nxt[free_idx]       = in_r.periodic;
            out_word_nxt.which_slot = SLOT_FW'(free_idx);
          end else begin
            out_word_nxt.event_res  = EV_FAILED;
            out_word_nxt.which_slot = '0;
          end
        end
        KIND_DESTROY: begin
          if (live) used_nxt[slot_idx] = 1'b0;
        end
        KIND_PAUSE: begin
          if (live) hold_nxt[slot_idx] = 1'b1;
        end
        KIND_CONTINUE, KIND_RESET: begin
          if (live) hold_nxt[slot_idx] = 1'b0;
        end
        KIND_QUERY: begin
          if (!live) begin
            out_word_nxt.event_res = EV_FINISHED;
          end else if (cnt_q == '0) begin
            used_nxt[slot_idx]     = 1'b0;
            out_word_nxt.event_res = EV_FINISHED;
          end else begin
            out_word_nxt.event_res = EV_RUNNING;
          end
        end
        default: begin
          out_word_nxt.event_res = EV_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      hold_r       <= '0;
      cyc_r        <= '0;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      hold_r       <= hold_nxt;
      cyc_r        <= cyc_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_word;
    end
    proc_idx_r <= rd_addr;
    pend_idx_r <= pend_idx_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_word   = out_word_r;
  assign out_strobe = out_strobe_r;

endmodule

[hdl/multi_slot_timer_engine.sv]
// Top level of the multi-slot timer engine: controller plus datapath.
// Depends on mste_pkg, mste_ctrl, mste_dp (and mste_ram through the datapath).
//
//   Channel   Ports                     Handshake
//   input     in_word, start, busy      word taken at an edge with start high, busy low
//   result    out_word, out_strobe      word valid for the one cycle out_strobe is high
//
// A tick word with nonzero elapsed keeps busy high after acceptance through a
// decode state, a scan state that reads each slot in turn through the counter
// RAM read port plus a drain step, and a flush state. Every other word passes
// through decode and execute, and a tick with zero elapsed through decode and
// flush. The next word is taken only while busy is low, so a new word is never
// taken before the last one is through. Results leave through an output
// register, in the cycle after they are formed.
// Reset is synchronous and active low; it frees all slots at once, and the
// reload and counter RAMs need no clearing since create writes them first.
// The receiver cannot stall, so results are never held back.
//
// The engine keeps a small table of timers. Each slot has in-use, paused and
// cyclic marks in flip-flops and a reload value and counter in two RAMs. A
// tick walks the slots in rising order, one per cycle; expiries come out in
// that order, and the final result of every word carries last.
module multi_slot_timer_engine
  import mste_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mste_in_t  in_word,
  output mste_out_t out_word,
  output logic      out_strobe
);

  mste_cmd_t cmd;
  mste_sts_t sts;

  // The controller owns sequencing and the slot scan counter.
  mste_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath owns all slot state and forms the result words.
  mste_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .sts        (sts),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

endmodule

[hdl/mste_chk.sv]
// Port-level checker for the multi-slot timer engine, bound to the top level.
// Depends on mste_pkg and multi_slot_timer_engine.
module mste_chk
  import mste_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input mste_out_t out_word,
  input logic      out_strobe
);

  // Reset leaves the engine idle with no result pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_strobe)
    else $error("engine not idle after reset");

  // An accepted word makes the engine busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after accept");

  // The final result of a word is never followed directly by another result.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.last |=> !out_strobe)
    else $error("result right after a final result");

  // A failed create names slot zero and ends its word.
  a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_word.event_res == EV_FAILED) |->
      (out_word.which_slot == '0) && out_word.last)
    else $error("malformed create failure");

  // Only defined event codes appear.
  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.event_res <= EV_FINISHED))
    else $error("undefined event code");

endmodule

bind multi_slot_timer_engine mste_chk u_chk (.*);

[tb/testbench.sv]
// Self-checking testbench for the multi-slot timer engine: directed corner cases,
// then random traffic under several sender gap rates. Depends on mste_pkg and
// multi_slot_timer_engine only.
module testbench;
  import mste_pkg::*;

  // The kind field has one code that the engine does not define. It must be
  // answered like an unused slot command.
  localparam logic [2:0] KIND_SPARE = 3'd7;

  // Ticks visit every slot, so the engine stays busy through a whole slot scan.
  localparam int DRAIN_CYCLES = 2 * LIVE_SLOTS + 8;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  mste_in_t  in_word;
  mste_out_t out_word;
  logic      out_strobe;

  // This is our own copy of the slot table. It moves forward once for every
  // word that the engine accepts.
  bit          slot_used   [1 << SLOT_FW];
  bit          slot_held   [1 << SLOT_FW];
  bit          slot_cyclic [1 << SLOT_FW];
  logic [31:0] slot_reload [1 << SLOT_FW];
  logic [31:0] slot_count  [1 << SLOT_FW];

  // These are the results that the engine still owes us, oldest first.
  mste_out_t due_events [$];
  mste_out_t want;

  int error_count    = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int expiries_seen  = 0;
  int failed_creates = 0;

  multi_slot_timer_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // This is a hard stop. Even the slowest legal run finishes far earlier.
  initial begin
    #2_000_000;
    $display("%0t: timeout, the engine stopped making progress", $time);
    $display("DONE: errors detected");
    $finish;
  end

  // Work out the results of one accepted word and update the slot table. All
  // results of a word go on the due list in order, and the final one carries last.
  function automatic void apply_timer_word(input mste_in_t w);
    mste_out_t   burst [$];
    mste_out_t   r;
    logic [31:0] prior;
    bit          live;
    bit          found;
    live = (int'(w.slot) < LIVE_SLOTS) && slot_used[w.slot];
    r = '0;
    r.event_res  = EV_DONE;
    r.which_slot = w.slot;
    case (w.kind)
      KIND_TICK: begin
        // A zero elapsed count leaves every counter alone.
        if (w.elapsed != 8'd0) begin
          for (int i = 0; i < LIVE_SLOTS; i++) begin
            if (slot_used[i] && !slot_held[i]) begin
              prior = slot_count[i];
              slot_count[i] = (32'(w.elapsed) >= prior) ? 32'd0 : prior - 32'(w.elapsed);
              // A one-shot reports only the fall to zero. A cyclic slot reports
              // every time it hits zero, even when its reload value is zero.
              if (slot_count[i] == 32'd0 && (slot_cyclic[i] || prior != 32'd0)) begin
                r.event_res  = EV_EXPIRED;
                r.which_slot = SLOT_FW'(i);
                burst.push_back(r);
                if (slot_cyclic[i]) slot_count[i] = slot_reload[i];
              end
            end
          end
        end
        if (burst.size() == 0) begin
          r.event_res  = EV_DONE;
          r.which_slot = '0;
          burst.push_back(r);
        end
      end
      KIND_CREATE: begin
        r.event_res  = EV_FAILED;
        r.which_slot = '0;
        found = 1'b0;
        for (int i = 0; i < LIVE_SLOTS; i++) begin
          if (!found && !slot_used[i]) begin
            found          = 1'b1;
            slot_used[i]   = 1'b1;
            slot_held[i]   = 1'b0;
            slot_cyclic[i] = w.periodic;
            slot_reload[i] = w.period;
            slot_count[i]  = w.period;
            r.event_res    = EV_DONE;
            r.which_slot   = SLOT_FW'(i);
          end
        end
        burst.push_back(r);
      end
      KIND_DESTROY: begin
        if (live) slot_used[w.slot] = 1'b0;
        burst.push_back(r);
      end
      KIND_PAUSE: begin
        if (live) slot_held[w.slot] = 1'b1;
        burst.push_back(r);
      end
      KIND_CONTINUE: begin
        if (live) slot_held[w.slot] = 1'b0;
        burst.push_back(r);
      end
      KIND_RESET: begin
        if (live) begin
          slot_held[w.slot]  = 1'b0;
          slot_count[w.slot] = slot_reload[w.slot];
        end
        burst.push_back(r);
      end
      KIND_QUERY: begin
        // A free slot has nothing pending. A slot that has run down is freed here.
        if (!live) begin
          r.event_res = EV_FINISHED;
        end else if (slot_count[w.slot] == 32'd0) begin
          slot_used[w.slot] = 1'b0;
          r.event_res = EV_FINISHED;
        end else begin
          r.event_res = EV_RUNNING;
        end
        burst.push_back(r);
      end
      default: begin
        burst.push_back(r);
      end
    endcase
    for (int k = 0; k < burst.size(); k++) begin
      r = burst[k];
      r.last = (k == burst.size() - 1);
      due_events.push_back(r);
    end
  endfunction

  task automatic note_mismatch(input string field, input int unsigned want_v,
                               input int unsigned got_v);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  // The input handshake and the result strobe are both sampled at the rising
  // edge, before the engine's own updates take effect. A result always belongs
  // to an earlier word, so it is checked before a word accepted at the same edge
  // is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        results_seen++;
        if (out_word.event_res == EV_EXPIRED) expiries_seen++;
        if (out_word.event_res == EV_FAILED) failed_creates++;
        if (due_events.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, got event %0d slot %0d last %0d",
                   $time, out_word.event_res, out_word.which_slot, out_word.last);
        end else begin
          want = due_events.pop_front();
          if (out_word.event_res !== want.event_res)
            note_mismatch("event_res", want.event_res, out_word.event_res);
          if (out_word.which_slot !== want.which_slot)
            note_mismatch("which_slot", want.which_slot, out_word.which_slot);
          if (out_word.last !== want.last)
            note_mismatch("last", want.last, out_word.last);
        end
      end
      if (start && !busy) apply_timer_word(in_word);
    end
  end

  function automatic mste_in_t make_word(input logic [2:0] kind, input int slot,
                                         input logic [31:0] period, input bit periodic,
                                         input int elapsed);
    mste_in_t w;
    w.kind     = kind;
    w.slot     = SLOT_FW'(slot);
    w.period   = period;
    w.periodic = periodic;
    w.elapsed  = 8'(elapsed);
    return w;
  endfunction

  // Send one word. With gap_pct percent odds the sender first goes quiet for a
  // while. Then it holds start high until the engine takes the word. The task
  // returns at the edge of acceptance, and start stays high, so the next word
  // can follow at once.
  task automatic send_word(input mste_in_t w, input int gap_pct);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // Most commands should hit a live slot, or else they do nothing of interest.
  function automatic logic [SLOT_FW-1:0] pick_slot();
    int live_list [$];
    for (int i = 0; i < LIVE_SLOTS; i++)
      if (slot_used[i]) live_list.push_back(i);
    if (live_list.size() != 0 && $urandom_range(0, 99) < 75)
      return SLOT_FW'(live_list[$urandom_range(0, live_list.size() - 1)]);
    return SLOT_FW'($urandom_range(0, (1 << SLOT_FW) - 1));
  endfunction

  // Fields that a kind does not use still carry random bits. Periods are
  // mostly short so that slots expire often. Some are tiny and a few use the
  // full width.
  function automatic mste_in_t random_word();
    mste_in_t w;
    int       roll;
    roll       = $urandom_range(0, 99);
    w.slot     = pick_slot();
    w.periodic = 1'($urandom_range(0, 1));
    w.elapsed  = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 64)) : 8'($urandom);
    if (roll < 30)      w.kind = KIND_TICK;
    else if (roll < 50) w.kind = KIND_CREATE;
    else if (roll < 58) w.kind = KIND_DESTROY;
    else if (roll < 65) w.kind = KIND_PAUSE;
    else if (roll < 72) w.kind = KIND_CONTINUE;
    else if (roll < 79) w.kind = KIND_RESET;
    else if (roll < 97) w.kind = KIND_QUERY;
    else                w.kind = KIND_SPARE;
    roll = $urandom_range(0, 99);
    if (roll < 60)      w.period = 32'($urandom_range(0, 300));
    else if (roll < 85) w.period = 32'($urandom_range(0, 12));
    else                w.period = $urandom;
    return w;
  endfunction

  // Fill the whole table with a mix of one-shot and cyclic slots, then ask for
  // one more. The mix includes a one-shot of period zero, a cyclic of period
  // zero and an all-ones period. The extra create has to fail.
  task automatic test_fill_and_overflow();
    send_word(make_word(KIND_CREATE, 0, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_CREATE, 0, 32'd0, 1'b1, 0), 0);
    send_word(make_word(KIND_CREATE, 0, 32'd3, 1'b0, 0), 0);
    send_word(make_word(KIND_CREATE, 0, 32'hFFFF_FFFF, 1'b1, 0), 0);
    for (int i = 4; i < LIVE_SLOTS; i++)
      send_word(make_word(KIND_CREATE, 0, 32'(i * 16), 1'(i), 0), 0);
    send_word(make_word(KIND_CREATE, 0, 32'hFFFF_FFFF, 1'b1, 0), 0);
  endtask

  // A zero tick must change nothing. A full tick expires almost every slot in
  // one burst, while the period-zero one-shot stays silent.
  task automatic test_tick_cases();
    send_word(make_word(KIND_TICK, 0, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_TICK, 0, 32'd0, 1'b0, 255), 0);
  endtask

  // These are the slot commands on live and free slots. A query on a running
  // slot answers running. A query on a run-down one-shot frees it, and the
  // same query again then finds a free slot. The paused slot must sit out the
  // tick, while the zero cyclic fires again.
  task automatic test_slot_commands();
    send_word(make_word(KIND_QUERY, 3, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_QUERY, 2, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_QUERY, 2, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_DESTROY, 2, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_PAUSE, 5, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_TICK, 0, 32'd0, 1'b0, 1), 0);
    send_word(make_word(KIND_CONTINUE, 5, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_RESET, 3, 32'd0, 1'b0, 0), 0);
    send_word(make_word(KIND_SPARE, 15, 32'hFFFF_FFFF, 1'b1, 255), 0);
  endtask

  task automatic test_random_traffic(input int count, input int gap_pct);
    for (int n = 0; n < count; n++) send_word(random_word(), gap_pct);
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_overflow();
    test_tick_cases();
    test_slot_commands();

    // Run one phase at full rate, then two phases where the sender pauses.
    // The result side can never stall, so only the sender is throttled.
    test_random_traffic(145, 0);
    test_random_traffic(145, 63);
    test_random_traffic(145, 37);
    start <= 1'b0;

    // Let the last results drain. After that, any further strobe is an error.
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words; checked %0d results, of them %0d expiries and %0d failed creates.",
             words_sent, results_seen, expiries_seen, failed_creates);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mste_pkg.sv
hdl/mste_ram.sv
hdl/mste_ctrl.sv
hdl/mste_dp.sv
hdl/multi_slot_timer_engine.sv
hdl/mste_chk.sv
tb/testbench.sv
